@@ hdl/rmlp_pkg.sv @@
// ----------------------------------------------------------------------------
// rmlp_pkg
// Shared types, codes and constants of the ray-marched light polygon unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmlp_pkg;

   localparam int DEF_MAX_CASTERS      = 16;
   localparam int DEF_MAX_RAYS         = 63;
   localparam int DEF_SINE_TABLE_DEPTH = 1024;

   localparam int COORD_W = 24;
   localparam int STEP_W  = 12;
   localparam int REACH_W = 20;
   localparam int TRAV_W  = 21;
   localparam int RAYS_W  = 6;
   localparam int CNT_W   = 5;
   localparam int SLOT_W  = 4;

   localparam logic [TRAV_W-1:0] STEP_Q8 = TRAV_W'(1280);

   localparam longint unsigned ONE_Q30     = 64'd1073741824;
   localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
   localparam longint unsigned PI_Q30      = 64'd3373259426;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CAST = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RAY_COUNT    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CASTER_COUNT = 3'd4;

   localparam logic [RAYS_W-1:0] RAY_COUNT_RESET    = 6'd32;
   localparam logic [CNT_W-1:0]  CASTER_COUNT_RESET = 5'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DSET,
      ST_DIV,
      ST_ROM,
      ST_INIT,
      ST_RD,
      ST_CHK,
      ST_MOVE,
      ST_MOVE2,
      ST_FAR,
      ST_EMIT,
      ST_CTR
   } rmlp_state_type;

   typedef struct packed {
      logic cast_start;
      logic load;
      logic div_set;
      logic div_step;
      logic rom_rd;
      logic ray_init;
      logic box_rd;
      logic box_next;
      logic move;
      logic dbl;
      logic emit_ray;
      logic emit_ctr;
   } rmlp_cmd_type;

   typedef struct packed {
      logic hit;
      logic last_box;
      logic no_boxes;
      logic far;
      logic last_ray;
      logic rays_zero;
   } rmlp_status_type;

   // Step of one axis for a Q30 angle: Q1.14 sine, scaled by 5.0 in Q8.
   // Evaluated at elaboration only, to fill the direction table.
   function automatic logic signed [STEP_W-1:0] rmlp_step(longint unsigned theta);
      longint unsigned th;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned v;
      logic            neg;
      th  = theta;
      neg = 1'b0;
      if (th >= TWO_PI_Q30) begin
         th = th - TWO_PI_Q30;
      end
      if (th >= PI_Q30) begin
         th  = th - PI_Q30;
         neg = 1'b1;
      end
      if (th > HALF_PI_Q30) begin
         th = PI_Q30 - th;
      end
      x2 = (th * th) >> 30;
      t  = ONE_Q30 - x2 / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (th * t) >> 30;
      s  = (s + 64'd32768) >> 16;
      v  = (s * 64'd1280 + 64'd8192) >> 14;
      return neg ? -STEP_W'(v) : STEP_W'(v);
   endfunction

endpackage

`default_nettype wire

@@ hdl/rmlp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmlp_ctrl
// Sequencer: angle division, table read, box sweep, march and emit per ray, then the centre vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module rmlp_ctrl #(
   parameter int NUM_W = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic                     req_operation,
   input  wire rmlp_pkg::rmlp_status_type status,
   output rmlp_pkg::rmlp_cmd_type        cmd,
   output logic                          busy
);
   import rmlp_pkg::*;

   localparam int DC_W = $clog2(NUM_W + 1);

   rmlp_state_type  state_ff, state_in;
   logic [DC_W-1:0] dcnt_ff, dcnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dcnt_in  = dcnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_operation == OP_CAST) begin
                  cmd.cast_start = 1'b1;
                  state_in = status.rays_zero ? ST_CTR : ST_DSET;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_DSET: begin
            cmd.div_set = 1'b1;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DC_W'(NUM_W - 1)) begin
               state_in = ST_ROM;
            end
         end
         ST_ROM: begin
            cmd.rom_rd = 1'b1;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.ray_init = 1'b1;
            state_in = status.no_boxes ? ST_MOVE : ST_RD;
         end
         ST_RD: begin
            cmd.box_rd = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (status.hit) begin
               state_in = ST_MOVE2;
            end else if (status.last_box) begin
               state_in = ST_MOVE;
            end else begin
               cmd.box_next = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = ST_FAR;
         end
         ST_MOVE2: begin
            cmd.move = 1'b1;
            cmd.dbl  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_FAR: begin
            if (status.far) begin
               state_in = ST_EMIT;
            end else begin
               state_in = status.no_boxes ? ST_MOVE : ST_RD;
            end
         end
         ST_EMIT: begin
            cmd.emit_ray = 1'b1;
            state_in = status.last_ray ? ST_CTR : ST_DSET;
         end
         ST_CTR: begin
            cmd.emit_ctr = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // a hit ends the ray after a double move
   a_dbl_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE2) |=> (state_ff == ST_EMIT))
      else $error("double move not followed by emit");
   // division always runs its full length before the table read
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROM) |-> $past(dcnt_ff) == DC_W'(NUM_W - 1))
      else $error("short division");
   // only cast items leave idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && req_operation == OP_LOAD) |=> (state_ff == ST_IDLE))
      else $error("load left idle");

endmodule

`default_nettype wire

@@ hdl/rmlp_dp.sv @@
// ----------------------------------------------------------------------------
// rmlp_dp
// Datapath: box table, direction table, angle divider, probe and result words.
// ----------------------------------------------------------------------------
`default_nettype none

module rmlp_dp #(
   parameter int MAX_CASTERS      = rmlp_pkg::DEF_MAX_CASTERS,
   parameter int MAX_RAYS         = rmlp_pkg::DEF_MAX_RAYS,
   parameter int SINE_TABLE_DEPTH = rmlp_pkg::DEF_SINE_TABLE_DEPTH,
   parameter int NUM_W            = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rmlp_pkg::rmlp_cmd_type          cmd,
   output rmlp_pkg::rmlp_status_type            status,
   input  wire logic [rmlp_pkg::RAYS_W-1:0]     ray_count,
   input  wire logic [rmlp_pkg::CNT_W-1:0]      caster_count,
   input  wire logic [rmlp_pkg::SLOT_W-1:0]     req_caster_slot,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_box_min_x,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_box_min_y,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_box_max_x,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_box_max_y,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_light_x,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_light_y,
   input  wire logic [rmlp_pkg::REACH_W-1:0]    req_reach,
   output logic                                 rsp_valid,
   output logic [rmlp_pkg::RAYS_W-1:0]          rsp_vertex_number,
   output logic signed [rmlp_pkg::COORD_W-1:0]  rsp_vertex_x,
   output logic signed [rmlp_pkg::COORD_W-1:0]  rsp_vertex_y,
   output logic                                 rsp_last
);
   import rmlp_pkg::*;

   localparam int AW = (MAX_CASTERS > 1) ? $clog2(MAX_CASTERS) : 1;
   localparam int BW = $clog2(MAX_CASTERS + 1);
   localparam int KW = $clog2(SINE_TABLE_DEPTH);
   localparam int RW = RAYS_W + 1;
   localparam int BOX_W = 4 * COORD_W;
   localparam logic signed [COORD_W+1:0] C_MAX = (COORD_W+2)'(8388607);
   localparam logic signed [COORD_W+1:0] C_MIN = -(COORD_W+2)'(8388608);

   // direction table: {step_x, step_y} per angle index
   logic [2*STEP_W-1:0] step_rom [SINE_TABLE_DEPTH];
   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
      localparam longint unsigned TH = (longint'(g) * TWO_PI_Q30) / SINE_TABLE_DEPTH;
      assign step_rom[g] = {rmlp_step(TH + HALF_PI_Q30), rmlp_step(TH)};
   end

   logic [BOX_W-1:0] box_mem [MAX_CASTERS];
   logic [BOX_W-1:0] box_q_ff;

   logic [RAYS_W-1:0]  rays;
   logic [BW-1:0]      boxes;
   logic [RAYS_W-1:0]  ray_idx_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   quo_ff;
   logic [RW-1:0]      rem_ff;
   logic [RW-1:0]      rem_sh;
   logic [RW:0]        rem_try;
   logic signed [STEP_W-1:0] sx_ff, sy_ff;
   logic signed [COORD_W-1:0] lx_ff, ly_ff, px_ff, py_ff;
   logic [REACH_W-1:0] reach_ff;
   logic [TRAV_W-1:0]  trav_ff;
   logic [BW-1:0]      box_idx_ff;
   logic               valid_ff;
   logic [RAYS_W-1:0]  num_out_ff;
   logic signed [COORD_W-1:0] ox_ff, oy_ff;
   logic               last_ff;

   assign rays  = (ray_count > RAYS_W'(MAX_RAYS)) ? RAYS_W'(MAX_RAYS) : ray_count;
   assign boxes = (32'(caster_count) > MAX_CASTERS) ? BW'(MAX_CASTERS) : BW'(caster_count);

   // restoring divider, one quotient bit a cycle
   assign rem_sh  = {rem_ff[RW-2:0], quo_ff[NUM_W-1]};
   assign rem_try = {1'b0, rem_sh} - (RW+1)'(rays);

   // hit test against the box read last cycle
   logic signed [COORD_W-1:0] lox, loy, hix, hiy, nx1, ny1, nx, ny;
   logic signed [COORD_W:0]   dxs, dys;
   logic dx_in, dy_in, dx_two, dy_two;

   assign {hiy, hix, loy, lox} = box_q_ff;
   assign nx1 = (px_ff < lox) ? lox : px_ff;
   assign nx  = (nx1 > hix) ? hix : nx1;
   assign ny1 = (py_ff < loy) ? loy : py_ff;
   assign ny  = (ny1 > hiy) ? hiy : ny1;
   assign dxs = (COORD_W+1)'(px_ff) - (COORD_W+1)'(nx);
   assign dys = (COORD_W+1)'(py_ff) - (COORD_W+1)'(ny);
   assign dx_in  = (dxs >= -(COORD_W+1)'(2)) && (dxs <= (COORD_W+1)'(2));
   assign dy_in  = (dys >= -(COORD_W+1)'(2)) && (dys <= (COORD_W+1)'(2));
   assign dx_two = (dxs == (COORD_W+1)'(2)) || (dxs == -(COORD_W+1)'(2));
   assign dy_two = (dys == (COORD_W+1)'(2)) || (dys == -(COORD_W+1)'(2));

   // march with saturation
   logic signed [COORD_W+1:0] mx, my, x_sum, y_sum;
   logic signed [COORD_W-1:0] x_sat, y_sat;
   logic [TRAV_W-1:0]         trav_in;

   assign mx    = cmd.dbl ? ((COORD_W+2)'(sx_ff) <<< 1) : (COORD_W+2)'(sx_ff);
   assign my    = cmd.dbl ? ((COORD_W+2)'(sy_ff) <<< 1) : (COORD_W+2)'(sy_ff);
   assign x_sum = (COORD_W+2)'(px_ff) + mx;
   assign y_sum = (COORD_W+2)'(py_ff) + my;
   assign x_sat = (x_sum > C_MAX) ? COORD_W'(C_MAX) :
                  (x_sum < C_MIN) ? COORD_W'(C_MIN) : COORD_W'(x_sum);
   assign y_sat = (y_sum > C_MAX) ? COORD_W'(C_MAX) :
                  (y_sum < C_MIN) ? COORD_W'(C_MIN) : COORD_W'(y_sum);
   assign trav_in = trav_ff + STEP_Q8;

   always_ff @(posedge clock) begin
      if (cmd.load && (32'(req_caster_slot) < MAX_CASTERS)) begin
         box_mem[AW'(req_caster_slot)] <= {req_box_max_y, req_box_max_x,
                                           req_box_min_y, req_box_min_x};
      end
      if (cmd.box_rd) begin
         box_q_ff <= box_mem[box_idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cast_start) begin
         lx_ff      <= req_light_x;
         ly_ff      <= req_light_y;
         reach_ff   <= req_reach;
         ray_idx_ff <= '0;
         num_ff     <= '0;
      end
      if (cmd.div_set) begin
         rem_ff <= '0;
         quo_ff <= num_ff;
      end
      if (cmd.div_step) begin
         if (!rem_try[RW]) begin
            rem_ff <= rem_try[RW-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
      if (cmd.rom_rd) begin
         {sx_ff, sy_ff} <= step_rom[quo_ff[KW-1:0]];
      end
      if (cmd.ray_init) begin
         px_ff      <= lx_ff;
         py_ff      <= ly_ff;
         trav_ff    <= '0;
         box_idx_ff <= '0;
      end
      if (cmd.box_next) begin
         box_idx_ff <= box_idx_ff + 1'b1;
      end
      if (cmd.move) begin
         px_ff      <= x_sat;
         py_ff      <= y_sat;
         trav_ff    <= trav_in;
         box_idx_ff <= '0;
      end
      if (cmd.emit_ray) begin
         ray_idx_ff <= ray_idx_ff + 1'b1;
         num_ff     <= num_ff + NUM_W'(SINE_TABLE_DEPTH);
         num_out_ff <= ray_idx_ff;
         ox_ff      <= px_ff;
         oy_ff      <= py_ff;
         last_ff    <= 1'b0;
      end
      if (cmd.emit_ctr) begin
         num_out_ff <= rays;
         ox_ff      <= lx_ff;
         oy_ff      <= ly_ff;
         last_ff    <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit_ray | cmd.emit_ctr;
      end
   end

   assign status.hit       = dx_in && dy_in && !(dx_two && dy_two);
   assign status.last_box  = ((box_idx_ff + 1'b1) == boxes);
   assign status.no_boxes  = (boxes == '0);
   assign status.far       = (trav_ff > TRAV_W'(reach_ff));
   assign status.last_ray  = ((RW'(ray_idx_ff) + 1'b1) == RW'(rays));
   assign status.rays_zero = (rays == '0);

   assign rsp_valid         = valid_ff;
   assign rsp_vertex_number = num_out_ff;
   assign rsp_vertex_x      = ox_ff;
   assign rsp_vertex_y      = oy_ff;
   assign rsp_last          = last_ff;

endmodule

`default_nettype wire

@@ hdl/ray_marched_light_polygon_unit.sv @@
// ----------------------------------------------------------------------------
// ray_marched_light_polygon_unit
// Marches rays from a light through a table of shadow-caster boxes.
// ----------------------------------------------------------------------------
// A load item writes one box and leaves busy low. A cast item keeps busy high
// while, per ray, it runs the angle division (NUM_W = 16 at default sizes)
// and the table read, then marches. Every march step sweeps the active boxes,
// reading the box memory one box at a time and checking each box before the
// next read. A step that misses moves one step, and the ray ends once its
// travel passes the reach; a step that hits moves a double step and ends the
// ray. The ray's word is then emitted and shows on the ports the cycle after.
// The centre vertex is emitted after the last ray (straight after the item
// when the ray count is zero) and shows in the cycle in which busy drops.
// Result words appear with rsp_valid for a single cycle and cannot be stalled;
// the receiver must take every word. start is ignored while busy is high.
`default_nettype none

module ray_marched_light_polygon_unit #(
   parameter int MAX_CASTERS      = rmlp_pkg::DEF_MAX_CASTERS,
   parameter int MAX_RAYS         = rmlp_pkg::DEF_MAX_RAYS,
   parameter int SINE_TABLE_DEPTH = rmlp_pkg::DEF_SINE_TABLE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_operation,
   input  wire logic [rmlp_pkg::SLOT_W-1:0]         req_caster_slot,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_box_min_x,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_box_min_y,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_box_max_x,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_box_max_y,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_light_x,
   input  wire logic signed [rmlp_pkg::COORD_W-1:0] req_light_y,
   input  wire logic [rmlp_pkg::REACH_W-1:0]        req_reach,
   output logic                                     rsp_valid,
   output logic [rmlp_pkg::RAYS_W-1:0]              rsp_vertex_number,
   output logic signed [rmlp_pkg::COORD_W-1:0]      rsp_vertex_x,
   output logic signed [rmlp_pkg::COORD_W-1:0]      rsp_vertex_y,
   output logic                                     rsp_last,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [rmlp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [31:0]                         pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);
   import rmlp_pkg::*;

   localparam int NUM_W = $clog2(MAX_RAYS * SINE_TABLE_DEPTH);

   logic [RAYS_W-1:0] ray_count_ff;
   logic [CNT_W-1:0]  caster_count_ff;
   logic              wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_count_ff    <= RAY_COUNT_RESET;
         caster_count_ff <= CASTER_COUNT_RESET;
      end else if (wr) begin
         if (paddr == CSR_RAY_COUNT) begin
            ray_count_ff <= pwdata[RAYS_W-1:0];
         end
         if (paddr == CSR_CASTER_COUNT) begin
            caster_count_ff <= pwdata[CNT_W-1:0];
         end
      end
   end

   always_comb begin
      case (paddr)
         CSR_RAY_COUNT:    prdata = 32'(ray_count_ff);
         CSR_CASTER_COUNT: prdata = 32'(caster_count_ff);
         default:          prdata = '0;
      endcase
   end

   rmlp_cmd_type    cmd;
   rmlp_status_type status;

   rmlp_ctrl #(
      .NUM_W (NUM_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   rmlp_dp #(
      .MAX_CASTERS      (MAX_CASTERS),
      .MAX_RAYS         (MAX_RAYS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .NUM_W            (NUM_W)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .ray_count         (ray_count_ff),
      .caster_count      (caster_count_ff),
      .req_caster_slot   (req_caster_slot),
      .req_box_min_x     (req_box_min_x),
      .req_box_min_y     (req_box_min_y),
      .req_box_max_x     (req_box_max_x),
      .req_box_max_y     (req_box_max_y),
      .req_light_x       (req_light_x),
      .req_light_y       (req_light_y),
      .req_reach         (req_reach),
      .rsp_valid         (rsp_valid),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_vertex_x      (rsp_vertex_x),
      .rsp_vertex_y      (rsp_vertex_y),
      .rsp_last          (rsp_last)
   );

   // the centre word closes the run and frees the unit
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("busy after centre word");
   // ray words come only while a cast runs
   a_ray_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("ray word outside a cast");
   // an accepted cast makes the unit busy
   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_CAST) |=> busy)
      else $error("cast not taken");

endmodule

`default_nettype wire

@@ bench/ray_marched_light_polygon_unit_tb.sv @@
// ----------------------------------------------------------------------------
// ray_marched_light_polygon_unit_tb
// Self-checking bench for the light polygon unit: loads caster boxes, casts
// lights under several ray and box counts, and checks every vertex word
// against an in-bench march of the same rays.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_marched_light_polygon_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rmlp_pkg::*;

   localparam int    BOX_SLOTS = DEF_MAX_CASTERS;
   localparam int    RAY_LIMIT = DEF_MAX_RAYS;
   localparam int    DIR_STEPS = DEF_SINE_TABLE_DEPTH;
   localparam longint COORD_HI = 64'sd8388607;
   localparam longint COORD_LO = -64'sd8388608;

   typedef struct {
      logic                      op;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] light_x;
      logic signed [COORD_W-1:0] light_y;
      logic [REACH_W-1:0]        reach;
   } light_req_type;

   typedef struct {
      logic [RAYS_W-1:0]         num;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
   } vertex_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_operation;
   logic [SLOT_W-1:0]         req_caster_slot;
   logic signed [COORD_W-1:0] req_box_min_x;
   logic signed [COORD_W-1:0] req_box_min_y;
   logic signed [COORD_W-1:0] req_box_max_x;
   logic signed [COORD_W-1:0] req_box_max_y;
   logic signed [COORD_W-1:0] req_light_x;
   logic signed [COORD_W-1:0] req_light_y;
   logic [REACH_W-1:0]        req_reach;
   logic                      rsp_valid;
   logic [RAYS_W-1:0]         rsp_vertex_number;
   logic signed [COORD_W-1:0] rsp_vertex_x;
   logic signed [COORD_W-1:0] rsp_vertex_y;
   logic                      rsp_last;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_W-1:0]     paddr;
   logic [31:0]               pwdata;
   logic [31:0]               prdata;
   logic                      pready;

   // bench copy of the block's state
   logic signed [COORD_W-1:0] box_lo_x [BOX_SLOTS];
   logic signed [COORD_W-1:0] box_lo_y [BOX_SLOTS];
   logic signed [COORD_W-1:0] box_hi_x [BOX_SLOTS];
   logic signed [COORD_W-1:0] box_hi_y [BOX_SLOTS];
   int unsigned               cfg_rays;
   int unsigned               cfg_boxes;

   vertex_type                vertex_q[$];
   int                        mismatch_count;
   int                        burst_left;
   bit                        steady;
   longint                    scene_x;
   longint                    scene_y;

   ray_marched_light_polygon_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_caster_slot(req_caster_slot),
      .req_box_min_x(req_box_min_x), .req_box_min_y(req_box_min_y),
      .req_box_max_x(req_box_max_x), .req_box_max_y(req_box_max_y),
      .req_light_x(req_light_x), .req_light_y(req_light_y),
      .req_reach(req_reach), .rsp_valid(rsp_valid),
      .rsp_vertex_number(rsp_vertex_number), .rsp_vertex_x(rsp_vertex_x),
      .rsp_vertex_y(rsp_vertex_y), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic int sine_q14(longint unsigned theta);
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      bit              neg;
      neg = 1'b0;
      if (theta >= TWO_PI_Q30) begin
         theta = theta - TWO_PI_Q30;
      end
      if (theta >= PI_Q30) begin
         theta = theta - PI_Q30;
         neg   = 1'b1;
      end
      if (theta > HALF_PI_Q30) begin
         theta = (theta <= PI_Q30) ? PI_Q30 - theta : 0;
      end
      x2 = (theta * theta) >> 30;
      t  = ONE_Q30 - x2 / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (theta * t) >> 30;
      s  = (s + 32768) >> 16;
      return neg ? -int'(s) : int'(s);
   endfunction

   function automatic longint axis_step(int c);
      longint unsigned m;
      longint          v;
      m = (c < 0) ? longint'(-c) : longint'(c);
      v = longint'((m * 1280 + 8192) >> 14);
      return (c < 0) ? -v : v;
   endfunction

   function automatic longint clip_coord(longint v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
   endfunction

   function automatic bit probe_touches(longint px, longint py, int unsigned nbox);
      longint nx;
      longint ny;
      longint dx;
      longint dy;
      for (int unsigned b = 0; b < nbox; b++) begin
         nx = px;
         ny = py;
         if (nx < box_lo_x[b]) nx = box_lo_x[b];
         if (nx > box_hi_x[b]) nx = box_hi_x[b];
         if (ny < box_lo_y[b]) ny = box_lo_y[b];
         if (ny > box_hi_y[b]) ny = box_hi_y[b];
         dx = (px > nx) ? px - nx : nx - px;
         dy = (py > ny) ? py - ny : ny - py;
         if (dx * dx + dy * dy < 7) return 1'b1;
      end
      return 1'b0;
   endfunction

   // march every ray of one light and queue the vertices it yields
   task automatic march_light(light_req_type r);
      int unsigned     rays;
      int unsigned     nbox;
      longint unsigned dir;
      longint unsigned theta;
      longint          sx;
      longint          sy;
      longint          px;
      longint          py;
      int unsigned     trav;
      vertex_type      v;
      rays = (cfg_rays > RAY_LIMIT) ? RAY_LIMIT : cfg_rays;
      nbox = (cfg_boxes > BOX_SLOTS) ? BOX_SLOTS : cfg_boxes;
      for (int unsigned i = 0; i < rays; i++) begin
         dir   = (longint'(i) * DIR_STEPS) / rays;
         theta = (dir * TWO_PI_Q30) / DIR_STEPS;
         sx    = axis_step(sine_q14(theta + HALF_PI_Q30));
         sy    = axis_step(sine_q14(theta));
         px    = r.light_x;
         py    = r.light_y;
         trav  = 0;
         forever begin
            if (probe_touches(px, py, nbox)) begin
               px = clip_coord(px + 2 * sx);
               py = clip_coord(py + 2 * sy);
               break;
            end
            px   = clip_coord(px + sx);
            py   = clip_coord(py + sy);
            trav = trav + 1280;
            if (trav > r.reach) break;
         end
         v.num  = RAYS_W'(i);
         v.x    = COORD_W'(px);
         v.y    = COORD_W'(py);
         v.last = 1'b0;
         vertex_q.push_back(v);
      end
      v.num  = RAYS_W'(rays);
      v.x    = r.light_x;
      v.y    = r.light_y;
      v.last = 1'b1;
      vertex_q.push_back(v);
   endtask

   // ----------------------------------------------------------------- checking
   task automatic report_mismatch(string what);
      $display("[%0t] vertex check failed: %s", $realtime, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      vertex_type e;
      if (!reset && rsp_valid) begin
         if (vertex_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word number %0d", rsp_vertex_number));
         end else begin
            e = vertex_q.pop_front();
            if (rsp_vertex_number !== e.num || rsp_vertex_x !== e.x ||
                rsp_vertex_y !== e.y || rsp_last !== e.last) begin
               report_mismatch($sformatf("got n=%0d x=%0d y=%0d l=%b, want n=%0d x=%0d y=%0d l=%b",
                  rsp_vertex_number, rsp_vertex_x, rsp_vertex_y, rsp_last,
                  e.num, e.x, e.y, e.last));
            end
         end
      end
   end

   // ------------------------------------------------------------------ driving
   // Leaves start high; the pacing and drain tasks lower it.
   task automatic send_word(light_req_type r);
      start           <= 1'b1;
      req_operation   <= r.op;
      req_caster_slot <= r.slot;
      req_box_min_x   <= r.min_x;
      req_box_min_y   <= r.min_y;
      req_box_max_x   <= r.max_x;
      req_box_max_y   <= r.max_y;
      req_light_x     <= r.light_x;
      req_light_y     <= r.light_y;
      req_reach       <= r.reach;
      do @(posedge clock); while (busy);
      if (r.op == OP_LOAD) begin
         box_lo_x[r.slot] = r.min_x;
         box_lo_y[r.slot] = r.min_y;
         box_hi_x[r.slot] = r.max_x;
         box_hi_y[r.slot] = r.max_y;
      end else begin
         march_light(r);
      end
   endtask

   task automatic pace();
      int gap;
      gap = 0;
      if (!steady) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
            gap        = $urandom_range(1, 9);
         end
         burst_left--;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      // drop start first so the last word is not taken again once idle
      start <= 1'b0;
      while (vertex_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == CSR_RAY_COUNT) cfg_rays = 32'(data[RAYS_W-1:0]);
      else cfg_boxes = 32'(data[CNT_W-1:0]);
   endtask

   task automatic set_counts(int unsigned rays, int unsigned boxes);
      drain();
      csr_write(CSR_RAY_COUNT, rays);
      csr_write(CSR_CASTER_COUNT, boxes);
   endtask

   function automatic light_req_type load_word(int slot, longint x0, longint y0,
                                               longint x1, longint y1);
      light_req_type r;
      r         = '{default: '0};
      r.op      = OP_LOAD;
      r.slot    = SLOT_W'(slot);
      r.min_x   = COORD_W'(x0);
      r.min_y   = COORD_W'(y0);
      r.max_x   = COORD_W'(x1);
      r.max_y   = COORD_W'(y1);
      r.light_x = COORD_W'($urandom);
      r.light_y = COORD_W'($urandom);
      r.reach   = REACH_W'($urandom);
      return r;
   endfunction

   function automatic light_req_type cast_word(longint lx, longint ly, int unsigned reach);
      light_req_type r;
      r         = '{default: '0};
      r.op      = OP_CAST;
      r.slot    = SLOT_W'($urandom);
      r.min_x   = COORD_W'($urandom);
      r.min_y   = COORD_W'($urandom);
      r.max_x   = COORD_W'($urandom);
      r.max_y   = COORD_W'($urandom);
      r.light_x = COORD_W'(lx);
      r.light_y = COORD_W'(ly);
      r.reach   = REACH_W'(reach);
      return r;
   endfunction

   // -------------------------------------------------------------------- tests
   task automatic test_box_table();
      // every slot gets written before any cast can read it
      send_word(load_word(0, COORD_LO, COORD_LO, COORD_HI, COORD_HI));
      send_word(load_word(1, 5000, 5000, -5000, -5000));
      for (int s = 2; s < BOX_SLOTS; s++) begin
         send_word(load_word(s, 2000 + 4000 * s, -3000, 4000 + 4000 * s, 3000));
         pace();
      end
   endtask

   task automatic test_count_edges();
      // no boxes: rays run the full reach, including the widest reach
      set_counts(1, 0);
      send_word(cast_word(0, 0, 20'hFFFFF));
      set_counts(63, 0);
      send_word(cast_word(COORD_HI, COORD_LO, 0));
      send_word(cast_word(-1234567, 7654321, 20'hFFFFF));
      // no rays: centre vertex only
      set_counts(0, 31);
      send_word(cast_word(COORD_LO, COORD_HI, 3000));
      // over-range caster count: slot 0 covers the plane, every ray hits
      set_counts(63, 31);
      send_word(cast_word(COORD_HI, COORD_HI, 20'hFFFFF));
      // move slot 0 far away, then the inverted box in slot 1 and the row along +x
      send_word(load_word(0, 900000, 900000, 910000, 910000));
      set_counts(8, 2);
      send_word(cast_word(0, 0, 12800));
      set_counts(5, 16);
      send_word(cast_word(0, 0, 40000));
      send_word(cast_word(60000, 0, 0));
   endtask

   task automatic scene_load(int slot);
      longint x0;
      longint y0;
      if ($urandom_range(0, 9) == 0) begin
         send_word(load_word(slot, $urandom, $urandom, $urandom, $urandom));
      end else begin
         x0 = scene_x + $urandom_range(0, 30000) - 15000;
         y0 = scene_y + $urandom_range(0, 30000) - 15000;
         send_word(load_word(slot, x0, y0, x0 + $urandom_range(600, 9000),
                             y0 + $urandom_range(600, 9000)));
      end
   endtask

   task automatic test_random_scenes();
      int unsigned rays;
      for (int ph = 0; ph < 4; ph++) begin
         rays = (ph == 3) ? 63 : $urandom_range(1, 40);
         if (ph == 0) begin
            scene_x = 0;
            scene_y = 0;
         end else begin
            scene_x = longint'($urandom_range(0, 16000000)) - 8000000;
            scene_y = longint'($urandom_range(0, 16000000)) - 8000000;
         end
         steady = (ph == 1);
         for (int s = 0; s < BOX_SLOTS; s++) begin
            scene_load(s);
            pace();
         end
         set_counts(rays, $urandom_range(0, 31));
         for (int n = 0; n < 6; n++) begin
            if ($urandom_range(0, 5) == 0) begin
               scene_load($urandom_range(0, BOX_SLOTS - 1));
            end else if ($urandom_range(0, 7) == 0) begin
               send_word(cast_word($urandom, $urandom, $urandom_range(0, 12800)));
            end else begin
               send_word(cast_word(scene_x + $urandom_range(0, 30000) - 15000,
                                   scene_y + $urandom_range(0, 30000) - 15000,
                                   $urandom_range(0, 12800)));
            end
            pace();
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = OP_LOAD;
      req_caster_slot = '0;
      req_box_min_x   = '0;
      req_box_min_y   = '0;
      req_box_max_x   = '0;
      req_box_max_y   = '0;
      req_light_x     = '0;
      req_light_y     = '0;
      req_reach       = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      cfg_rays        = 32'(RAY_COUNT_RESET);
      cfg_boxes       = 32'(CASTER_COUNT_RESET);
      mismatch_count  = 0;
      burst_left      = 0;
      steady          = 1'b0;
      scene_x         = 0;
      scene_y         = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_box_table();
      test_count_edges();
      test_random_scenes();

      drain();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && vertex_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
